// File: sv/acm_pkg.sv
// shared constants and opcodes for the aho-corasick match counter
`timescale 1ns / 1ps

package acm_pkg;

  localparam int OP_W     = 3;
  localparam int SYMBOL_W = 5;
  localparam int ID_W     = 12;
  localparam int MCOUNT_W = 32;

  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
  localparam logic [OP_W-1:0] OP_PATTERN = 3'd1;
  localparam logic [OP_W-1:0] OP_BUILD   = 3'd2;
  localparam logic [OP_W-1:0] OP_TEXT    = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY   = 3'd4;

  // link memory holds two tables side by side
  localparam logic LINK_FAIL  = 1'b0;
  localparam logic LINK_ORDER = 1'b1;

endpackage

// File: sv/acm_if.sv
// valid/ready channel interfaces for the command and result streams
`timescale 1ns / 1ps

interface acm_in_if import acm_pkg::*;;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [SYMBOL_W-1:0] symbol;
  logic                last;
  logic [ID_W-1:0]     query_node;

  modport source (output valid, output opcode, output symbol, output last,
                  output query_node, input ready);
  modport sink (input valid, input opcode, input symbol, input last,
                input query_node, output ready);
endinterface

interface acm_out_if import acm_pkg::*;;
  logic                valid;
  logic                ready;
  logic [ID_W-1:0]     node_id;
  logic [MCOUNT_W-1:0] match_count;
  logic                done_res;
  logic                full_res;

  modport source (output valid, output node_id, output match_count,
                  output done_res, output full_res, input ready);
  modport sink (input valid, input node_id, input match_count,
                input done_res, input full_res, output ready);
endinterface

// File: sv/acm_ram.sv
// simple dual-port ram, one write and one registered read per cycle
`timescale 1ns / 1ps

module acm_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/aho_corasick_match_counter_top.sv
// aho-corasick match counter: trie build, text matching and count query
//
// Commands arrive on in_ch (valid/ready) one transaction at a time; results
// leave on out_ch (valid/ready) from an output register. in_ch.ready is high
// only while the sequencer is idle, so one command is worked at a time.
// Work per command:
//   query reads the count memory; a pattern char reads the child slot and
//   clears a fresh row when a node is allocated; clear sweeps the root row.
//   text char: walks the fail links until a child is found, clears all node
//   counts on the first character of a text, and pushes counts down the
//   breadth-first order on the last character.
//   build: visits every node in breadth-first order, each letter slot, and
//   walks the fail links to set each child's fail link.
// Reads of the child, link or count memory are registered, and a write that
// uses read data comes in a later state; each memory has one write port.
// After reset the root row and the root entries of the node tables are
// cleared before the first command is taken.
// A stalled receiver holds its result; the block finishes the next command
// and then waits with it until the output register frees.
`timescale 1ns / 1ps

module aho_corasick_match_counter_top import acm_pkg::*; #(
  parameter int MAX_NODES  = 4096,
  parameter int ALPHABET   = 26,
  parameter int COUNT_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  acm_in_if.sink    in_ch,
  acm_out_if.source out_ch
);

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int SYM_W  = $clog2(ALPHABET);
  localparam int IDX_W  = $clog2(ALPHABET + 1);
  localparam int ROW    = 2 ** SYM_W;

  localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);
  localparam logic [NODE_W-1:0] NULL_NODE = '0;

  typedef enum logic [4:0] {
    S_ROOT, S_IDLE, S_DECODE, S_PAT_RD, S_ALLOC, S_PAT_END,
    S_ZERO, S_TXT_W, S_TXT_C, S_TXT_L, S_TXT_BUMP,
    S_PROP, S_PROP_N, S_PROP_F, S_PROP_A, S_TXT_FIN, S_QRY,
    S_BLD_START, S_BLD_F1, S_BLD_HEAD, S_BLD_R, S_BLD_FR, S_BLD_CH,
    S_BLD_X, S_BLD_W, S_BLD_WC, S_BLD_WL, S_BLD_WF, S_BLD_WB, S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  logic [OP_W-1:0]       op_r, op_nxt;
  logic [SYMBOL_W-1:0]   sym_r, sym_nxt;
  logic                  last_r, last_nxt;
  logic [ID_W-1:0]       q_r, q_nxt;

  logic [CNT_W-1:0]      node_total_r, node_total_nxt;
  logic [NODE_W-1:0]     cursor_r, cursor_nxt;
  logic [NODE_W-1:0]     match_r, match_nxt;
  logic                  text_open_r, text_open_nxt;
  logic                  dropped_r, dropped_nxt;
  logic [CNT_W-1:0]      bfs_count_r, bfs_count_nxt;

  logic [CNT_W-1:0]      head_r, head_nxt;
  logic [CNT_W-1:0]      tail_r, tail_nxt;
  logic [CNT_W-1:0]      zc_r, zc_nxt;
  logic [NODE_W-1:0]     rn_r, rn_nxt;
  logic [NODE_W-1:0]     fr_r, fr_nxt;
  logic [NODE_W-1:0]     x_r, x_nxt;
  logic [NODE_W-1:0]     w_r, w_nxt;
  logic [NODE_W-1:0]     t_r, t_nxt;
  logic [NODE_W-1:0]     f_r, f_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [SYM_W-1:0]      sweep_r, sweep_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  emit_clear_r, emit_clear_nxt;

  logic [NODE_W-1:0]     res_node_r, res_node_nxt;
  logic [COUNT_BITS-1:0] res_count_r, res_count_nxt;
  logic                  res_done_r, res_done_nxt;
  logic                  res_full_r, res_full_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0]     out_node_r, out_node_nxt;
  logic [COUNT_BITS-1:0] out_count_r, out_count_nxt;
  logic                  out_done_r, out_done_nxt;
  logic                  out_full_r, out_full_nxt;

  logic                     child_we;
  logic [NODE_W+SYM_W-1:0]  child_waddr, child_raddr;
  logic [NODE_W-1:0]        child_wdata, child_rdata;
  logic                     link_we;
  logic [NODE_W:0]          link_waddr, link_raddr;
  logic [NODE_W-1:0]        link_wdata, link_rdata;
  logic                     cnt_we;
  logic [NODE_W-1:0]        cnt_waddr, cnt_raddr;
  logic [COUNT_BITS-1:0]    cnt_wdata, cnt_rdata;

  logic [COUNT_BITS-1:0]    add_b;
  logic [COUNT_BITS:0]      sum;
  logic [COUNT_BITS-1:0]    sat_sum;
  logic [SYM_W-1:0]         sym_idx;
  logic [SYM_W-1:0]         idx_sym;
  logic                     sym_ok;
  logic                     q_ok;

  acm_ram #(.DEPTH(MAX_NODES * ROW), .WIDTH(NODE_W)) u_child (
    .clk(clk), .we(child_we), .waddr(child_waddr), .wdata(child_wdata),
    .raddr(child_raddr), .rdata(child_rdata)
  );

  acm_ram #(.DEPTH(2 * MAX_NODES), .WIDTH(NODE_W)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_rdata)
  );

  acm_ram #(.DEPTH(MAX_NODES), .WIDTH(COUNT_BITS)) u_count (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  // saturating add shared by the visit bump and the push-down
  assign add_b   = (state_r == S_PROP_A) ? cnt_r : COUNT_BITS'(1);
  assign sum     = {1'b0, cnt_rdata} + {1'b0, add_b};
  assign sat_sum = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];

  assign sym_idx = SYM_W'(sym_r);
  assign idx_sym = SYM_W'(idx_r);
  assign sym_ok  = (sym_r < ALPHABET);
  assign q_ok    = (q_r < node_total_r) && (q_r < MAX_NODES);

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.node_id     = ID_W'(out_node_r);
  assign out_ch.match_count = MCOUNT_W'(out_count_r);
  assign out_ch.done_res    = out_done_r;
  assign out_ch.full_res    = out_full_r;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    sym_nxt        = sym_r;
    last_nxt       = last_r;
    q_nxt          = q_r;
    node_total_nxt = node_total_r;
    cursor_nxt     = cursor_r;
    match_nxt      = match_r;
    text_open_nxt  = text_open_r;
    dropped_nxt    = dropped_r;
    bfs_count_nxt  = bfs_count_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    zc_nxt         = zc_r;
    rn_nxt         = rn_r;
    fr_nxt         = fr_r;
    x_nxt          = x_r;
    w_nxt          = w_r;
    t_nxt          = t_r;
    f_nxt          = f_r;
    idx_nxt        = idx_r;
    sweep_nxt      = sweep_r;
    cnt_nxt        = cnt_r;
    emit_clear_nxt = emit_clear_r;
    res_node_nxt   = res_node_r;
    res_count_nxt  = res_count_r;
    res_done_nxt   = res_done_r;
    res_full_nxt   = res_full_r;
    out_valid_nxt  = out_valid_r;
    out_node_nxt   = out_node_r;
    out_count_nxt  = out_count_r;
    out_done_nxt   = out_done_r;
    out_full_nxt   = out_full_r;

    child_we    = 1'b0;
    child_waddr = '0;
    child_wdata = '0;
    child_raddr = '0;
    link_we     = 1'b0;
    link_waddr  = '0;
    link_wdata  = '0;
    link_raddr  = '0;
    cnt_we      = 1'b0;
    cnt_waddr   = '0;
    cnt_wdata   = '0;
    cnt_raddr   = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_ROOT: begin
        // clear the root row and the root entries of the node tables
        child_we    = 1'b1;
        child_waddr = {ROOT_NODE, sweep_r};
        if (sweep_r == SYM_W'(0)) begin
          cnt_we     = 1'b1;
          cnt_waddr  = NULL_NODE;
          link_we    = 1'b1;
          link_waddr = {LINK_FAIL, ROOT_NODE};
        end else if (sweep_r == SYM_W'(1)) begin
          cnt_we    = 1'b1;
          cnt_waddr = ROOT_NODE;
        end
        sweep_nxt = sweep_r + SYM_W'(1);
        if (sweep_r == SYM_W'(ROW - 1)) begin
          node_total_nxt = CNT_W'(2);
          cursor_nxt     = ROOT_NODE;
          match_nxt      = ROOT_NODE;
          text_open_nxt  = 1'b0;
          dropped_nxt    = 1'b0;
          bfs_count_nxt  = '0;
          if (emit_clear_r) begin
            res_node_nxt  = NULL_NODE;
            res_count_nxt = '0;
            res_done_nxt  = 1'b1;
            res_full_nxt  = 1'b0;
            state_nxt     = S_EMIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = in_ch.opcode;
          sym_nxt   = in_ch.symbol;
          last_nxt  = in_ch.last;
          q_nxt     = in_ch.query_node;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        case (op_r)
          OP_CLEAR: begin
            sweep_nxt      = '0;
            emit_clear_nxt = 1'b1;
            state_nxt      = S_ROOT;
          end
          OP_PATTERN: begin
            if (!dropped_r && sym_ok) begin
              child_raddr = {cursor_r, sym_idx};
              state_nxt   = S_PAT_RD;
            end else begin
              state_nxt = S_PAT_END;
            end
          end
          OP_BUILD: begin
            state_nxt = S_BLD_START;
          end
          OP_TEXT: begin
            if (!text_open_r) begin
              zc_nxt    = '0;
              state_nxt = S_ZERO;
            end else begin
              w_nxt     = match_r;
              state_nxt = S_TXT_W;
            end
          end
          OP_QUERY: begin
            if (q_ok) begin
              cnt_raddr = NODE_W'(q_r);
              state_nxt = S_QRY;
            end else begin
              res_node_nxt  = NODE_W'(q_r);
              res_count_nxt = '0;
              res_done_nxt  = 1'b0;
              res_full_nxt  = 1'b0;
              state_nxt     = S_EMIT;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_PAT_RD: begin
        if (child_rdata != NULL_NODE) begin
          cursor_nxt = child_rdata;
          state_nxt  = S_PAT_END;
        end else if (node_total_r >= MAX_NODES) begin
          dropped_nxt = 1'b1;
          state_nxt   = S_PAT_END;
        end else begin
          child_we    = 1'b1;
          child_waddr = {cursor_r, sym_idx};
          child_wdata = NODE_W'(node_total_r);
          x_nxt       = NODE_W'(node_total_r);
          sweep_nxt   = '0;
          state_nxt   = S_ALLOC;
        end
      end

      S_ALLOC: begin
        // fresh node: empty child row, zero count, no fail link
        child_we    = 1'b1;
        child_waddr = {x_r, sweep_r};
        if (sweep_r == SYM_W'(0)) begin
          cnt_we     = 1'b1;
          cnt_waddr  = x_r;
          link_we    = 1'b1;
          link_waddr = {LINK_FAIL, x_r};
        end
        sweep_nxt = sweep_r + SYM_W'(1);
        if (sweep_r == SYM_W'(ROW - 1)) begin
          node_total_nxt = node_total_r + CNT_W'(1);
          cursor_nxt     = x_r;
          state_nxt      = S_PAT_END;
        end
      end

      S_PAT_END: begin
        if (last_r) begin
          res_node_nxt  = dropped_r ? NULL_NODE : cursor_r;
          res_count_nxt = '0;
          res_done_nxt  = 1'b0;
          res_full_nxt  = dropped_r;
          cursor_nxt    = ROOT_NODE;
          dropped_nxt   = 1'b0;
          state_nxt     = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_ZERO: begin
        cnt_we    = 1'b1;
        cnt_waddr = NODE_W'(zc_r);
        zc_nxt    = zc_r + CNT_W'(1);
        if (zc_r == node_total_r - CNT_W'(1)) begin
          match_nxt     = ROOT_NODE;
          text_open_nxt = 1'b1;
          w_nxt         = ROOT_NODE;
          state_nxt     = S_TXT_W;
        end
      end

      S_TXT_W: begin
        if (!sym_ok || w_r == NULL_NODE) begin
          match_nxt = ROOT_NODE;
          cnt_raddr = ROOT_NODE;
          state_nxt = S_TXT_BUMP;
        end else begin
          child_raddr = {w_r, sym_idx};
          state_nxt   = S_TXT_C;
        end
      end

      S_TXT_C: begin
        if (child_rdata != NULL_NODE) begin
          match_nxt = child_rdata;
          cnt_raddr = child_rdata;
          state_nxt = S_TXT_BUMP;
        end else begin
          link_raddr = {LINK_FAIL, w_r};
          state_nxt  = S_TXT_L;
        end
      end

      S_TXT_L: begin
        w_nxt     = link_rdata;
        state_nxt = S_TXT_W;
      end

      S_TXT_BUMP: begin
        cnt_we    = 1'b1;
        cnt_waddr = match_r;
        cnt_wdata = sat_sum;
        if (last_r) begin
          zc_nxt    = bfs_count_r;
          state_nxt = S_PROP;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_PROP: begin
        // walk breadth-first order backwards, root excluded
        if (zc_r <= CNT_W'(1)) begin
          cnt_raddr = match_r;
          state_nxt = S_TXT_FIN;
        end else begin
          link_raddr = {LINK_ORDER, NODE_W'(zc_r - CNT_W'(1))};
          zc_nxt     = zc_r - CNT_W'(1);
          state_nxt  = S_PROP_N;
        end
      end

      S_PROP_N: begin
        link_raddr = {LINK_FAIL, link_rdata};
        cnt_raddr  = link_rdata;
        state_nxt  = S_PROP_F;
      end

      S_PROP_F: begin
        f_nxt     = link_rdata;
        cnt_nxt   = cnt_rdata;
        cnt_raddr = link_rdata;
        state_nxt = S_PROP_A;
      end

      S_PROP_A: begin
        cnt_we    = 1'b1;
        cnt_waddr = f_r;
        cnt_wdata = sat_sum;
        state_nxt = S_PROP;
      end

      S_TXT_FIN: begin
        res_node_nxt  = match_r;
        res_count_nxt = cnt_rdata;
        res_done_nxt  = 1'b1;
        res_full_nxt  = 1'b0;
        text_open_nxt = 1'b0;
        state_nxt     = S_EMIT;
      end

      S_QRY: begin
        res_node_nxt  = NODE_W'(q_r);
        res_count_nxt = cnt_rdata;
        res_done_nxt  = 1'b0;
        res_full_nxt  = 1'b0;
        state_nxt     = S_EMIT;
      end

      S_BLD_START: begin
        link_we    = 1'b1;
        link_waddr = {LINK_ORDER, NULL_NODE};
        link_wdata = ROOT_NODE;
        head_nxt   = '0;
        tail_nxt   = CNT_W'(1);
        state_nxt  = S_BLD_F1;
      end

      S_BLD_F1: begin
        link_we    = 1'b1;
        link_waddr = {LINK_FAIL, ROOT_NODE};
        state_nxt  = S_BLD_HEAD;
      end

      S_BLD_HEAD: begin
        if (head_r == tail_r) begin
          bfs_count_nxt = tail_r;
          text_open_nxt = 1'b0;
          match_nxt     = ROOT_NODE;
          res_node_nxt  = NULL_NODE;
          res_count_nxt = '0;
          res_done_nxt  = 1'b1;
          res_full_nxt  = 1'b0;
          state_nxt     = S_EMIT;
        end else begin
          link_raddr = {LINK_ORDER, NODE_W'(head_r)};
          head_nxt   = head_r + CNT_W'(1);
          state_nxt  = S_BLD_R;
        end
      end

      S_BLD_R: begin
        rn_nxt     = link_rdata;
        link_raddr = {LINK_FAIL, link_rdata};
        state_nxt  = S_BLD_FR;
      end

      S_BLD_FR: begin
        fr_nxt    = link_rdata;
        idx_nxt   = '0;
        state_nxt = S_BLD_CH;
      end

      S_BLD_CH: begin
        if (idx_r == IDX_W'(ALPHABET)) begin
          state_nxt = S_BLD_HEAD;
        end else begin
          child_raddr = {rn_r, idx_sym};
          state_nxt   = S_BLD_X;
        end
      end

      S_BLD_X: begin
        if (child_rdata == NULL_NODE) begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_BLD_CH;
        end else begin
          x_nxt     = child_rdata;
          w_nxt     = fr_r;
          state_nxt = S_BLD_W;
        end
      end

      S_BLD_W: begin
        if (w_r == NULL_NODE) begin
          t_nxt     = NULL_NODE;
          state_nxt = S_BLD_WF;
        end else begin
          child_raddr = {w_r, idx_sym};
          state_nxt   = S_BLD_WC;
        end
      end

      S_BLD_WC: begin
        if (child_rdata != NULL_NODE) begin
          t_nxt     = child_rdata;
          state_nxt = S_BLD_WF;
        end else begin
          link_raddr = {LINK_FAIL, w_r};
          state_nxt  = S_BLD_WL;
        end
      end

      S_BLD_WL: begin
        w_nxt     = link_rdata;
        state_nxt = S_BLD_W;
      end

      S_BLD_WF: begin
        link_we    = 1'b1;
        link_waddr = {LINK_FAIL, x_r};
        link_wdata = (t_r == NULL_NODE) ? ROOT_NODE : t_r;
        state_nxt  = S_BLD_WB;
      end

      S_BLD_WB: begin
        if (tail_r < MAX_NODES) begin
          link_we    = 1'b1;
          link_waddr = {LINK_ORDER, NODE_W'(tail_r)};
          link_wdata = x_r;
          tail_nxt   = tail_r + CNT_W'(1);
        end
        idx_nxt   = idx_r + IDX_W'(1);
        state_nxt = S_BLD_CH;
      end

      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_node_nxt  = res_node_r;
          out_count_nxt = res_count_r;
          out_done_nxt  = res_done_r;
          out_full_nxt  = res_full_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_ROOT;
      sweep_r      <= '0;
      emit_clear_r <= 1'b0;
      out_valid_r  <= 1'b0;
      text_open_r  <= 1'b0;
      dropped_r    <= 1'b0;
      node_total_r <= CNT_W'(2);
      cursor_r     <= ROOT_NODE;
      match_r      <= ROOT_NODE;
      bfs_count_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      sweep_r      <= sweep_nxt;
      emit_clear_r <= emit_clear_nxt;
      out_valid_r  <= out_valid_nxt;
      text_open_r  <= text_open_nxt;
      dropped_r    <= dropped_nxt;
      node_total_r <= node_total_nxt;
      cursor_r     <= cursor_nxt;
      match_r      <= match_nxt;
      bfs_count_r  <= bfs_count_nxt;
    end
    op_r        <= op_nxt;
    sym_r       <= sym_nxt;
    last_r      <= last_nxt;
    q_r         <= q_nxt;
    head_r      <= head_nxt;
    tail_r      <= tail_nxt;
    zc_r        <= zc_nxt;
    rn_r        <= rn_nxt;
    fr_r        <= fr_nxt;
    x_r         <= x_nxt;
    w_r         <= w_nxt;
    t_r         <= t_nxt;
    f_r         <= f_nxt;
    idx_r       <= idx_nxt;
    cnt_r       <= cnt_nxt;
    res_node_r  <= res_node_nxt;
    res_count_r <= res_count_nxt;
    res_done_r  <= res_done_nxt;
    res_full_r  <= res_full_nxt;
    out_node_r  <= out_node_nxt;
    out_count_r <= out_count_nxt;
    out_done_r  <= out_done_nxt;
    out_full_r  <= out_full_nxt;
  end

endmodule

// File: bench/aho_corasick_match_counter_top_tb.sv
// self-checking testbench for the aho-corasick match counter
`timescale 1ns / 1ps

module aho_corasick_match_counter_top_tb;
  import acm_pkg::*;

  localparam int NODES_MAX = 4096;
  localparam int LETTERS   = 26;
  localparam int ITEM_GOAL = 1700;

  typedef struct packed {
    logic [ID_W-1:0]     node_id;
    logic [MCOUNT_W-1:0] match_count;
    logic                done_res;
    logic                full_res;
  } acm_result_t;

  logic clk;
  logic rst_n;

  acm_in_if  in_ch ();
  acm_out_if out_ch ();

  aho_corasick_match_counter_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow automaton
  logic [ID_W-1:0]     trie_child [0:NODES_MAX*LETTERS-1];
  logic [ID_W-1:0]     fail_to    [0:NODES_MAX-1];
  logic [MCOUNT_W-1:0] hits       [0:NODES_MAX-1];
  logic [ID_W-1:0]     level_seq  [0:NODES_MAX-1];
  int                  level_len;
  int                  node_used;
  int                  ins_at;
  int                  state_at;
  bit                  text_live;
  bit                  ins_lost;

  acm_result_t expected_results[$];
  int          errors;
  int          items_sent;
  bit          no_gaps;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic int child_at(int n, int s);
    if (n >= NODES_MAX || s >= LETTERS) return 0;
    return int'(trie_child[n*LETTERS+s]);
  endfunction

  function automatic int follow_fail(int n, int s);
    int guard;
    guard = 0;
    while (n != 0 && child_at(n, s) == 0) begin
      if (guard >= NODES_MAX) return 0;
      guard++;
      n = int'(fail_to[n]);
    end
    return n;
  endfunction

  function automatic void add_hits(int n, logic [MCOUNT_W-1:0] a);
    logic [MCOUNT_W:0] s;
    s = {1'b0, hits[n]} + {1'b0, a};
    hits[n] = s[MCOUNT_W] ? '1 : s[MCOUNT_W-1:0];
  endfunction

  function automatic int new_node();
    int n;
    n = node_used;
    for (int i = 0; i < LETTERS; i++) trie_child[n*LETTERS+i] = '0;
    fail_to[n] = '0;
    hits[n] = '0;
    node_used = n + 1;
    return n;
  endfunction

  function automatic void empty_trie();
    node_used = 1;
    void'(new_node());
    ins_at = 1;
    state_at = 1;
    text_live = 0;
    ins_lost = 0;
    level_len = 0;
  endfunction

  function automatic void link_fails();
    int head, tail, r, x, z, t;
    head = 0;
    tail = 1;
    level_seq[0] = ID_W'(1);
    fail_to[1] = '0;
    while (head < tail) begin
      r = int'(level_seq[head]);
      head++;
      for (int i = 0; i < LETTERS; i++) begin
        x = child_at(r, i);
        if (x == 0) continue;
        z = follow_fail(int'(fail_to[r]), i);
        t = (z != 0) ? child_at(z, i) : 0;
        fail_to[x] = ID_W'((t != 0) ? t : 1);
        if (tail < NODES_MAX) begin
          level_seq[tail] = ID_W'(x);
          tail++;
        end
      end
    end
    level_len = tail;
  endfunction

  function automatic void push_result(int n, logic [MCOUNT_W-1:0] c, bit d, bit f);
    acm_result_t r;
    r.node_id = ID_W'(n);
    r.match_count = c;
    r.done_res = d;
    r.full_res = f;
    expected_results.push_back(r);
  endfunction

  // works out what one accepted command should answer
  function automatic void predict_command(logic [OP_W-1:0] op, int sym, bit last,
                                          int q);
    int nx, x;
    case (op)
      OP_CLEAR: begin
        empty_trie();
        push_result(0, '0, 1'b1, 1'b0);
      end
      OP_PATTERN: begin
        if (!ins_lost && sym < LETTERS) begin
          nx = child_at(ins_at, sym);
          if (nx == 0) begin
            if (node_used >= NODES_MAX) ins_lost = 1;
            else begin
              nx = new_node();
              trie_child[ins_at*LETTERS+sym] = ID_W'(nx);
            end
          end
          if (nx != 0) ins_at = nx;
        end
        if (last) begin
          push_result(ins_lost ? 0 : ins_at, '0, 1'b0, ins_lost);
          ins_at = 1;
          ins_lost = 0;
        end
      end
      OP_BUILD: begin
        link_fails();
        text_live = 0;
        state_at = 1;
        push_result(0, '0, 1'b1, 1'b0);
      end
      OP_TEXT: begin
        if (!text_live) begin
          for (int i = 0; i < NODES_MAX; i++) hits[i] = '0;
          state_at = 1;
          text_live = 1;
        end
        x = follow_fail(state_at, sym);
        nx = (x != 0) ? child_at(x, sym) : 0;
        if (nx == 0) nx = 1;
        state_at = nx;
        add_hits(nx, MCOUNT_W'(1));
        if (last) begin
          // push counts down the fail links, deepest first
          for (int i = level_len; i > 1; i--)
            add_hits(int'(fail_to[level_seq[i-1]]), hits[level_seq[i-1]]);
          text_live = 0;
          push_result(state_at, hits[state_at], 1'b1, 1'b0);
        end
      end
      OP_QUERY: push_result(q, (q < node_used) ? hits[q] : '0, 1'b0, 1'b0);
      default: ;
    endcase
  endfunction

  task automatic send_command(logic [OP_W-1:0] op, int sym, bit last, int q);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.symbol     <= sym[SYMBOL_W-1:0];
    in_ch.last       <= last;
    in_ch.query_node <= q[ID_W-1:0];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_command(op, sym, last, q);
    items_sent++;
  endtask

  // sender goes quiet until every expected result has come back
  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // result side stalls
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    acm_result_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.node_id = out_ch.node_id;
      got.match_count = out_ch.match_count;
      got.done_res = out_ch.done_res;
      got.full_res = out_ch.full_res;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result transaction: node %0d count %0d done %b full %b",
                   got.node_id, got.match_count, got.done_res, got.full_res);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: expected node %0d count %0d done %b full %b, ",
                      "got node %0d count %0d done %b full %b"},
                     want.node_id, want.match_count, want.done_res, want.full_res,
                     got.node_id, got.match_count, got.done_res, got.full_res);
        end
      end
    end
  end

  task automatic test_directed();
    send_command(OP_CLEAR, 31, 1, 4095);
    send_command(OP_PATTERN, 0, 1, 0);          // single letter pattern
    send_command(OP_PATTERN, 25, 0, 0);
    send_command(OP_PATTERN, 31, 0, 0);         // out of range letter skipped
    send_command(OP_PATTERN, 0, 1, 0);
    send_command(OP_PATTERN, 26, 1, 0);         // nothing but a bad letter
    send_command(OP_PATTERN, 0, 1, 0);          // duplicate pattern
    send_command(OP_QUERY, 0, 0, 3);            // query before any text
    send_command(OP_BUILD, 0, 0, 0);
    send_command(OP_PATTERN, 1, 1, 0);          // inserted after the build
    send_command(OP_TEXT, 25, 0, 0);
    send_command(OP_TEXT, 0, 0, 0);
    send_command(OP_QUERY, 0, 0, 2);            // raw counts mid text
    send_command(OP_TEXT, 30, 0, 0);
    send_command(OP_TEXT, 0, 1, 0);
    send_command(OP_QUERY, 0, 0, 0);
    send_command(OP_QUERY, 0, 0, 1);
    send_command(OP_QUERY, 0, 0, 2);
    send_command(OP_QUERY, 0, 0, 4095);
    send_command(3'd5, 0, 1, 0);
    send_command(3'd6, 31, 0, 4095);
    send_command(3'd7, 0, 1, 0);
    send_command(OP_TEXT, 1, 1, 0);             // single letter text
    send_command(OP_BUILD, 0, 0, 0);
    send_command(OP_TEXT, 1, 1, 0);
  endtask

  task automatic test_full_trie();
    no_gaps = 1;
    send_command(OP_CLEAR, 0, 0, 0);
    for (int i = 0; i < NODES_MAX - 2; i++) send_command(OP_PATTERN, i % LETTERS, 0, 0);
    no_gaps = 0;
    send_command(OP_PATTERN, 3, 0, 0);
    send_command(OP_PATTERN, 4, 1, 0);          // dropped pattern
    send_command(OP_PATTERN, 7, 1, 0);          // no room for a new child
    send_command(OP_PATTERN, 0, 1, 0);          // existing path still fine
    send_command(OP_QUERY, 0, 0, 4095);
    send_command(OP_TEXT, 0, 0, 0);
    send_command(OP_QUERY, 0, 0, 2);
    wait_all_results();
    send_command(OP_CLEAR, 0, 0, 0);
  endtask

  function automatic int pick_letter(int span);
    if ($urandom_range(0, 19) == 0) return $urandom_range(LETTERS, 31);
    return $urandom_range(0, span - 1);
  endfunction

  task automatic test_random_sessions();
    int span, len;
    while (items_sent < ITEM_GOAL + NODES_MAX + 40) begin
      no_gaps = ($urandom_range(0, 5) == 0);
      span = ($urandom_range(0, 3) == 0) ? $urandom_range(2, LETTERS)
                                         : $urandom_range(2, 4);
      if ($urandom_range(0, 2) == 0)
        send_command(OP_CLEAR, $urandom, 1'($urandom), $urandom);
      repeat ($urandom_range(1, 6)) begin
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++)
          send_command(OP_PATTERN, pick_letter(span), i == len - 1, $urandom);
      end
      if ($urandom_range(0, 7) != 0)
        send_command(OP_BUILD, $urandom, 1'($urandom), $urandom);
      repeat ($urandom_range(1, 3)) begin
        len = $urandom_range(1, 20);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 14) == 0)
            send_command(OP_W'($urandom_range(5, 7)), $urandom, 1'($urandom), $urandom);
          if ($urandom_range(0, 19) == 0)
            send_command(OP_QUERY, 0, 0, $urandom_range(0, node_used + 1));
          send_command(OP_TEXT, pick_letter(span), i == len - 1, $urandom);
        end
        if ($urandom_range(0, 9) == 0)
          send_command(OP_PATTERN, pick_letter(span), 1, $urandom);
      end
      repeat ($urandom_range(1, 4))
        send_command(OP_QUERY, $urandom, 1'($urandom),
                     ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                                                 : $urandom_range(0, node_used + 1));
      if ($urandom_range(0, 9) == 0) wait_all_results();
    end
    no_gaps = 0;
  endtask

  initial begin
    #60_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    errors = 0;
    items_sent = 0;
    no_gaps = 0;
    for (int i = 0; i < NODES_MAX*LETTERS; i++) trie_child[i] = '0;
    for (int i = 0; i < NODES_MAX; i++) begin
      fail_to[i] = '0;
      hits[i] = '0;
      level_seq[i] = '0;
    end
    empty_trie();
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.opcode     <= OP_CLEAR;
    in_ch.symbol     <= '0;
    in_ch.last       <= 1'b0;
    in_ch.query_node <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    wait_all_results();
    test_full_trie();
    test_random_sessions();
    wait_all_results();
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
